### hdl/aabb_zone_collision_engine_unit_assert.svh
// Assertion macros for the zone collision engine
`ifndef AABB_ZONE_COLLISION_ENGINE_UNIT_ASSERT_SVH
`define AABB_ZONE_COLLISION_ENGINE_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define AZC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication
`define AZC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

### hdl/azc_pkg.sv
package azc_pkg;

	localparam int MaxZones = 64;
	localparam int IdxW     = $clog2(MaxZones);
	localparam int CntW     = $clog2(MaxZones + 1);
	localparam int QDepth   = 2;

	typedef enum logic [2:0] {
		CMD_CLEAR   = 3'd0,
		CMD_ADD     = 3'd1,
		CMD_POINT   = 3'd2,
		CMD_RES_X   = 3'd3,
		CMD_RES_Y   = 3'd4,
		CMD_EVENTS  = 3'd5,
		CMD_UNUSED6 = 3'd6,
		CMD_UNUSED7 = 3'd7
	} cmd_t;

	localparam logic [2:0] TYPE_SOLID      = 3'd0;
	localparam logic [2:0] TYPE_ONEWAY     = 3'd1;
	localparam logic [2:0] TYPE_DANGER     = 3'd2;
	localparam logic [2:0] TYPE_CHECKPOINT = 3'd5;

	// Event codes on the result
	localparam logic [2:0] EV_NONE       = 3'd0;
	localparam logic [2:0] EV_CHECKPOINT = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WALK,
		ST_DONE
	} walk_state_t;

	// Query request passed from front to back (prepared box edges)
	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] bx;
		logic [15:0] by;
		logic [15:0] bw;
		logic [15:0] bh;
		logic        vel_pos;
		logic        vel_neg;
		logic [7:0]  tmask;
		logic [15:0] p0;
		logic [15:0] p1;
		logic [CntW-1:0] total;
	} query_t;

	typedef struct packed {
		logic [15:0] new_pos;
		logic        wall_hit;
		logic        ground_hit;
		logic        ceiling_hit;
		logic        solid_hit;
		logic [2:0]  event_code;
		logic [15:0] event_zone;
		logic        table_full;
	} result_t;

endpackage

### hdl/azc_front.sv
// Front: takes requests, maintains zone table writes, prepares queries and immediate results
module azc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic [2:0]            cmd,
	input  logic [15:0]           pos_x,
	input  logic [15:0]           pos_y,
	input  logic [15:0]           prev_pos,
	input  logic [15:0]           box_off_x,
	input  logic [15:0]           box_off_y,
	input  logic [15:0]           box_w,
	input  logic [15:0]           box_h,
	input  logic [15:0]           velocity,
	input  logic [7:0]            class_mask,
	input  logic [63:0]           zone_bounds,
	input  logic [27:0]           zone_attr,
	output logic                  wr_en,
	output logic [azc_pkg::IdxW-1:0] wr_idx,
	output logic [91:0]           wr_data,
	output azc_pkg::query_t       q_data,
	output logic                  imm_valid,
	output azc_pkg::result_t      imm_res
);
	import azc_pkg::*;

	logic [CntW-1:0] total_q;
	logic            full;
	logic [15:0]     base;

	assign full = (total_q == CntW'(MaxZones));

	// Zone count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (req_valid && cmd == CMD_CLEAR) begin
			total_q <= '0;
		end else if (req_valid && cmd == CMD_ADD && !full) begin
			total_q <= total_q + 1'b1;
		end
	end

	assign wr_en   = req_valid && cmd == CMD_ADD && !full;
	assign wr_idx  = total_q[IdxW-1:0];
	assign wr_data = {zone_attr, zone_bounds};

	// Previous-position edges along the resolved axis
	assign base = (cmd == CMD_RES_Y) ? box_off_y : box_off_x;

	always_comb begin
		q_data.cmd     = cmd;
		q_data.pos_x   = pos_x;
		q_data.pos_y   = pos_y;
		q_data.bx      = box_off_x;
		q_data.by      = box_off_y;
		q_data.bw      = box_w;
		q_data.bh      = box_h;
		q_data.vel_pos = !velocity[15] && velocity != 16'd0;
		q_data.vel_neg = velocity[15];
		q_data.tmask   = class_mask;
		q_data.p0      = prev_pos + base;
		q_data.p1      = prev_pos + base + ((cmd == CMD_RES_Y) ? box_h : box_w);
		q_data.total   = total_q;
	end

	// Table commands and unused codes answer without a walk
	assign imm_valid = req_valid && (cmd == CMD_CLEAR || cmd == CMD_ADD ||
		cmd == CMD_UNUSED6 || cmd == CMD_UNUSED7);

	always_comb begin
		imm_res            = '0;
		imm_res.new_pos    = pos_x;
		imm_res.table_full = (cmd == CMD_ADD) && full;
	end

endmodule

### hdl/azc_back.sv
// Back: walks the zone table one entry at a time per query, taking the next query when idle
module azc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [azc_pkg::IdxW-1:0] wr_idx,
	input  logic [91:0]           wr_data,
	input  logic                  q_valid,
	input  azc_pkg::query_t       q_in,
	output logic                  q_pop,
	output logic                  res_valid,
	output azc_pkg::result_t      res
);
	import azc_pkg::*;

	logic [91:0]     mem [MaxZones];
	logic [91:0]     rd_q;
	walk_state_t     state_q, state_d;
	logic [CntW-1:0] idx_q;
	query_t          cur_q;
	logic [15:0]     p_q;
	logic            hit_a_q, hit_b_q;
	logic [2:0]      ev_q;
	logic [15:0]     evz_q;
	logic            last;

	// Zone fields
	logic signed [15:0] zx0, zy0, zx1, zy1;
	logic [15:0]        zid;
	logic [7:0]         ztm;
	logic [2:0]         zty;
	logic               zen, live;
	logic [15:0]        xpos, ypos;
	logic signed [15:0] ax0, ax1, ay0, ay1, p0, p1;
	logic               ovl;
	logic [15:0]        p_d;
	logic               a_d, b_d, stop_d;
	logic [2:0]         ev_d;
	logic [15:0]        evz_d;

	// Zone memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_data;
		rd_q <= mem[idx_q[IdxW-1:0]];
	end

	assign last = (idx_q + 1'b1 >= cur_q.total);

	// Walk sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_valid) state_d = (q_in.total == '0) ? ST_DONE : ST_READ;
			ST_READ: state_d = ST_WALK;
			ST_WALK: state_d = (last || stop_d) ? ST_DONE : ST_READ;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == ST_IDLE) && q_valid;
		res_valid = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) idx_q <= '0;
			else if (state_q == ST_WALK) idx_q <= idx_q + 1'b1;
		end
	end

	// One zone evaluated per walk step
	always_comb begin
		{zen, zty, ztm, zid} = rd_q[91:64];
		zx0  = rd_q[15:0];
		zy0  = rd_q[31:16];
		zx1  = rd_q[47:32];
		zy1  = rd_q[63:48];
		live = zen && ((ztm & cur_q.tmask) != 8'd0);
		xpos = (cur_q.cmd == CMD_RES_X) ? p_q : cur_q.pos_x;
		ypos = (cur_q.cmd == CMD_RES_Y) ? p_q : cur_q.pos_y;
		ax0  = xpos + cur_q.bx;
		ax1  = xpos + cur_q.bx + cur_q.bw;
		ay0  = ypos + cur_q.by;
		ay1  = ypos + cur_q.by + cur_q.bh;
		p0   = cur_q.p0;
		p1   = cur_q.p1;
		ovl  = ax0 < zx1 && ax1 > zx0 && ay0 < zy1 && ay1 > zy0;
		p_d = p_q; a_d = hit_a_q; b_d = hit_b_q; stop_d = 1'b0;
		ev_d = ev_q; evz_d = evz_q;
		case (cur_q.cmd)
			CMD_POINT: begin
				if (live && (zty == TYPE_SOLID || zty == TYPE_ONEWAY) &&
					$signed(cur_q.pos_x) >= zx0 && $signed(cur_q.pos_x) < zx1 &&
					$signed(cur_q.pos_y) >= zy0 && $signed(cur_q.pos_y) < zy1) begin
					a_d = 1'b1; stop_d = 1'b1;
				end
			end
			CMD_RES_X: begin
				if (live && zty == TYPE_SOLID && ovl) begin
					if (cur_q.vel_pos && p1 <= zx0) begin
						p_d = zx0 - cur_q.bx - cur_q.bw; a_d = 1'b1;
					end else if (cur_q.vel_neg && p0 >= zx1) begin
						p_d = zx1 - cur_q.bx; a_d = 1'b1;
					end
				end
			end
			CMD_RES_Y: begin
				if (live && zty == TYPE_ONEWAY) begin
					if (!cur_q.vel_neg && ax0 < zx1 && ax1 > zx0 && p1 <= zy0 &&
						ay1 >= zy0) begin
						p_d = zy0 - cur_q.by - cur_q.bh; a_d = 1'b1;
					end
				end else if (live && zty == TYPE_SOLID && ovl) begin
					if (!cur_q.vel_neg && p1 <= zy0) begin
						p_d = zy0 - cur_q.by - cur_q.bh; a_d = 1'b1;
					end else if (cur_q.vel_neg && p0 >= zy1) begin
						p_d = zy1 - cur_q.by; b_d = 1'b1;
					end
				end
			end
			CMD_EVENTS: begin
				if (live && ovl && zty >= TYPE_DANGER && zty <= TYPE_CHECKPOINT) begin
					ev_d = zty - 3'd1; evz_d = zid; stop_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q   <= q_in;
			p_q     <= (q_in.cmd == CMD_RES_Y) ? q_in.pos_y : q_in.pos_x;
			hit_a_q <= 1'b0; hit_b_q <= 1'b0;
			ev_q    <= '0;   evz_q   <= '0;
		end else if (state_q == ST_WALK) begin
			p_q <= p_d; hit_a_q <= a_d; hit_b_q <= b_d;
			ev_q <= ev_d; evz_q <= evz_d;
		end
	end

	always_comb begin
		res             = '0;
		res.new_pos     = p_q;
		res.wall_hit    = (cur_q.cmd == CMD_RES_X) && hit_a_q;
		res.ground_hit  = (cur_q.cmd == CMD_RES_Y) && hit_a_q;
		res.ceiling_hit = (cur_q.cmd == CMD_RES_Y) && hit_b_q;
		res.solid_hit   = (cur_q.cmd == CMD_POINT) && hit_a_q;
		res.event_code  = ev_q;
		res.event_zone  = evz_q;
	end

endmodule

### hdl/azc_queue.sv
// Short request queue between front and back
module azc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  azc_pkg::query_t din,
	input  logic            pop,
	output logic            not_empty,
	output logic            full,
	output azc_pkg::query_t dout
);
	import azc_pkg::*;

	query_t    slot_q [QDepth];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;

	assign not_empty = cnt_q != 2'd0;
	assign full      = cnt_q == 2'(QDepth);
	assign dout      = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### hdl/aabb_zone_collision_engine_unit.sv
// Channel  | Signals                                     | Handshake
// request  | cmd, pos_*, prev_pos, box_*, velocity, ...  | start & !busy
// result   | new_pos, *_hit, event_*, table_full         | done, one cycle
// Clear and add answer without a walk; queries walk the N zones stored
// (up to 64), reading and checking one zone per walk step.
// Reset clears the zone count and control; table contents stay undefined.
// busy is high while a query waits or walks or a request is still in flight.
module aabb_zone_collision_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] prev_pos,
	input  logic [15:0] box_off_x,
	input  logic [15:0] box_off_y,
	input  logic [15:0] box_w,
	input  logic [15:0] box_h,
	input  logic [15:0] velocity,
	input  logic [7:0]  class_mask,
	input  logic [63:0] zone_bounds,
	input  logic [27:0] zone_attr,
	output logic        done,
	output logic [15:0] new_pos,
	output logic        wall_hit,
	output logic        ground_hit,
	output logic        ceiling_hit,
	output logic        solid_hit,
	output logic [2:0]  event_code,
	output logic [15:0] event_zone,
	output logic        table_full
);
	import azc_pkg::*;

	logic               acc, wr_en, imm_valid, q_ne, q_full, q_pop, b_valid;
	logic [IdxW-1:0]    wr_idx;
	logic [91:0]        wr_data;
	query_t             q_data, q_out;
	result_t            imm_res, b_res, out_q;
	logic               done_q, inflight_q;

	assign acc = start && !busy;
	// One request in flight at a time keeps results in order
	assign busy = inflight_q;

	azc_front u_front (
		.clk, .arst_n, .req_valid(acc), .cmd, .pos_x, .pos_y, .prev_pos,
		.box_off_x, .box_off_y, .box_w, .box_h, .velocity, .class_mask,
		.zone_bounds, .zone_attr, .wr_en, .wr_idx, .wr_data, .q_data,
		.imm_valid, .imm_res
	);

	azc_queue u_queue (
		.clk, .arst_n, .push(acc && !imm_valid), .din(q_data), .pop(q_pop),
		.not_empty(q_ne), .full(q_full), .dout(q_out)
	);

	azc_back u_back (
		.clk, .arst_n, .wr_en, .wr_idx, .wr_data, .q_valid(q_ne), .q_in(q_out),
		.q_pop, .res_valid(b_valid), .res(b_res)
	);

	// Result register and in-flight tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			inflight_q <= 1'b0;
		end else begin
			done_q <= (acc && imm_valid) || b_valid;
			if (acc) inflight_q <= 1'b1;
			else if (done_q || q_full) inflight_q <= inflight_q && !done_q;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && imm_valid) out_q <= imm_res;
		else if (b_valid)     out_q <= b_res;
	end

	assign done        = done_q;
	assign new_pos     = out_q.new_pos;
	assign wall_hit    = out_q.wall_hit;
	assign ground_hit  = out_q.ground_hit;
	assign ceiling_hit = out_q.ceiling_hit;
	assign solid_hit   = out_q.solid_hit;
	assign event_code  = out_q.event_code;
	assign event_zone  = out_q.event_zone;
	assign table_full  = out_q.table_full;

endmodule

### hdl/azc_checker.sv
`include "aabb_zone_collision_engine_unit_assert.svh"

// Port-level checks on the engine
module azc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] event_code,
	input logic       table_full,
	input logic       wall_hit,
	input logic       ground_hit
);
	import azc_pkg::*;

	`AZC_ASSERT_NXT(a_busy_after_req, clk, arst_n, start && !busy, busy)
	`AZC_ASSERT_IMP(a_ev_range, clk, arst_n, done, event_code <= EV_CHECKPOINT)
	`AZC_ASSERT_IMP(a_one_flag, clk, arst_n, done && table_full,
		!wall_hit && !ground_hit && event_code == EV_NONE)
	`AZC_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done)
endmodule

bind aabb_zone_collision_engine_unit azc_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .event_code, .table_full,
	.wall_hit, .ground_hit
);

### tb/aabb_zone_collision_engine_unit_tb.sv
`timescale 1ns / 1ps

module aabb_zone_collision_engine_unit_tb;
	import azc_pkg::*;

	// one request as driven on the ports
	typedef struct {
		logic [2:0]  cmd;
		logic [15:0] pos_x, pos_y, prev_pos, box_off_x, box_off_y, box_w, box_h, velocity;
		logic [7:0]  class_mask;
		logic [63:0] zone_bounds;
		logic [27:0] zone_attr;
	} zone_req_t;

	// zone table model plus queue of expected results
	class zone_scoreboard;
		logic [63:0] rects[MaxZones];
		logic [27:0] attrs[MaxZones];
		int          n_zones;
		result_t     expected_q[$];
		int          errors;

		function void reset_table();
			n_zones = 0;
			errors  = 0;
		endfunction

		function bit overlaps(logic signed [15:0] ax0, ay0, ax1, ay1, zx0, zy0, zx1, zy1);
			return ax0 < zx1 && ax1 > zx0 && ay0 < zy1 && ay1 > zy0;
		endfunction

		function result_t resolve_zones(zone_req_t r);
			result_t o;
			logic signed [15:0] ax0, ax1, ay0, ay1, p0, p1, zx0, zy0, zx1, zy1;
			logic [15:0] crd;
			logic [2:0]  ztype;
			bit          zen, found, vpos, vneg;
			o         = '0;
			o.new_pos = r.pos_x;
			found     = 0;
			vpos      = $signed(r.velocity) > 0;
			vneg      = r.velocity[15];
			ax0 = r.pos_x + r.box_off_x;
			ax1 = r.pos_x + r.box_off_x + r.box_w;
			ay0 = r.pos_y + r.box_off_y;
			ay1 = r.pos_y + r.box_off_y + r.box_h;
			crd = (r.cmd == CMD_RES_Y) ? r.pos_y : r.pos_x;
			if (r.cmd == CMD_RES_X) begin
				p0 = r.prev_pos + r.box_off_x;
				p1 = r.prev_pos + r.box_off_x + r.box_w;
			end else begin
				p0 = r.prev_pos + r.box_off_y;
				p1 = r.prev_pos + r.box_off_y + r.box_h;
			end
			case (r.cmd)
				CMD_CLEAR: n_zones = 0;
				CMD_ADD: begin
					if (n_zones < MaxZones) begin
						rects[n_zones] = r.zone_bounds;
						attrs[n_zones] = r.zone_attr;
						n_zones++;
					end else
						o.table_full = 1'b1;
				end
				CMD_POINT, CMD_RES_X, CMD_RES_Y, CMD_EVENTS: begin
					for (int i = 0; i < n_zones && !found; i++) begin
						zx0   = rects[i][15:0];
						zy0   = rects[i][31:16];
						zx1   = rects[i][47:32];
						zy1   = rects[i][63:48];
						ztype = attrs[i][26:24];
						zen   = attrs[i][27] && (attrs[i][23:16] & r.class_mask) != 8'd0;
						if (!zen)
							continue;
						case (r.cmd)
							CMD_POINT: begin
								if ((ztype == TYPE_SOLID || ztype == TYPE_ONEWAY) &&
									$signed(r.pos_x) >= zx0 && $signed(r.pos_x) < zx1 &&
									$signed(r.pos_y) >= zy0 && $signed(r.pos_y) < zy1) begin
									o.solid_hit = 1'b1;
									found = 1;
								end
							end
							CMD_RES_X: begin
								if (ztype == TYPE_SOLID &&
									overlaps(ax0, ay0, ax1, ay1, zx0, zy0, zx1, zy1)) begin
									if (vpos && p1 <= zx0) begin
										crd = zx0 - r.box_off_x - r.box_w;
										o.wall_hit = 1'b1;
									end else if (vneg && p0 >= zx1) begin
										crd = zx1 - r.box_off_x;
										o.wall_hit = 1'b1;
									end
									ax0 = crd + r.box_off_x;
									ax1 = crd + r.box_off_x + r.box_w;
								end
							end
							CMD_RES_Y: begin
								if (ztype == TYPE_ONEWAY) begin
									// platform only catches a box from above that is not moving up
									if (!vneg && ax0 < zx1 && ax1 > zx0 && p1 <= zy0 &&
										ay1 >= zy0) begin
										crd = zy0 - r.box_off_y - r.box_h;
										o.ground_hit = 1'b1;
									end
								end else if (ztype == TYPE_SOLID &&
									overlaps(ax0, ay0, ax1, ay1, zx0, zy0, zx1, zy1)) begin
									if (!vneg && p1 <= zy0) begin
										crd = zy0 - r.box_off_y - r.box_h;
										o.ground_hit = 1'b1;
									end else if (vneg && p0 >= zy1) begin
										crd = zy1 - r.box_off_y;
										o.ceiling_hit = 1'b1;
									end
								end
								ay0 = crd + r.box_off_y;
								ay1 = crd + r.box_off_y + r.box_h;
							end
							default: begin
								if (ztype >= TYPE_DANGER && ztype <= TYPE_CHECKPOINT &&
									overlaps(ax0, ay0, ax1, ay1, zx0, zy0, zx1, zy1)) begin
									o.event_code = ztype - 3'd1;
									o.event_zone = attrs[i][15:0];
									found = 1;
								end
							end
						endcase
					end
					if (r.cmd == CMD_RES_X || r.cmd == CMD_RES_Y)
						o.new_pos = crd;
				end
				default: ;
			endcase
			return o;
		endfunction

		function void note_request(zone_req_t r);
			expected_q.push_back(resolve_zones(r));
		endfunction

		function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(result_t act);
			result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %p", $realtime, act);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			check_field("new_pos", e.new_pos, act.new_pos);
			check_field("wall_hit", 16'(e.wall_hit), 16'(act.wall_hit));
			check_field("ground_hit", 16'(e.ground_hit), 16'(act.ground_hit));
			check_field("ceiling_hit", 16'(e.ceiling_hit), 16'(act.ceiling_hit));
			check_field("solid_hit", 16'(e.solid_hit), 16'(act.solid_hit));
			check_field("event_code", 16'(e.event_code), 16'(act.event_code));
			check_field("event_zone", e.event_zone, act.event_zone);
			check_field("table_full", 16'(e.table_full), 16'(act.table_full));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [15:0] pos_x, pos_y, prev_pos, box_off_x, box_off_y, box_w, box_h, velocity;
	logic [7:0]  class_mask;
	logic [63:0] zone_bounds;
	logic [27:0] zone_attr;
	logic        done;
	logic [15:0] new_pos;
	logic        wall_hit, ground_hit, ceiling_hit, solid_hit, table_full;
	logic [2:0]  event_code;
	logic [15:0] event_zone;

	zone_scoreboard sb = new();
	int             idle_pct;
	int             req_count;

	aabb_zone_collision_engine_unit i_dut (.*);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// results are one-cycle strobes
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{new_pos, wall_hit, ground_hit, ceiling_hit, solid_hit,
				event_code, event_zone, table_full});
	end

	// drive one request, hold until the block takes it
	task automatic send_request(zone_req_t r);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cmd = r.cmd; pos_x = r.pos_x; pos_y = r.pos_y; prev_pos = r.prev_pos;
		box_off_x = r.box_off_x; box_off_y = r.box_off_y; box_w = r.box_w;
		box_h = r.box_h; velocity = r.velocity; class_mask = r.class_mask;
		zone_bounds = r.zone_bounds; zone_attr = r.zone_attr;
		start = 1'b1;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		req_count++;
		idle_pct = (req_count < 330) ? 0 : (req_count < 660) ? 63 : (req_count < 990) ? 30 : 0;
	endtask

	function automatic logic [15:0] near_coord();
		return 16'($urandom_range(0, 160)) - 16'd80;
	endfunction

	function automatic zone_req_t noise_req();
		zone_req_t r;
		r = '{3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom), {$urandom, $urandom}, 28'($urandom)};
		return r;
	endfunction

	// well-formed zone around the origin, sometimes inverted or odd-typed
	function automatic zone_req_t zone_add();
		zone_req_t   r;
		logic [15:0] x0, y0;
		r     = noise_req();
		r.cmd = CMD_ADD;
		x0    = near_coord();
		y0    = near_coord();
		r.zone_bounds = {y0 + 16'($urandom_range(0, 40)) - 16'd4, x0 + 16'($urandom_range(0, 40)) - 16'd4, y0, x0};
		r.zone_attr[27]    = $urandom_range(0, 9) != 0;
		r.zone_attr[26:24] = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) :
			$urandom_range(0, 5));
		if ($urandom_range(0, 3) != 0)
			r.zone_attr[23:16] = 8'hff;
		return r;
	endfunction

	// box query with small coordinates so that zones are actually hit
	function automatic zone_req_t query_req(logic [2:0] c);
		zone_req_t r;
		r           = noise_req();
		r.cmd       = c;
		r.pos_x     = near_coord();
		r.pos_y     = near_coord();
		r.prev_pos  = ((c == CMD_RES_Y) ? r.pos_y : r.pos_x) + 16'($urandom_range(0, 40)) - 16'd20;
		r.box_off_x = 16'($urandom_range(0, 8)) - 16'd4;
		r.box_off_y = 16'($urandom_range(0, 8)) - 16'd4;
		r.box_w     = 16'($urandom_range(0, 24)) - 16'd2;
		r.box_h     = 16'($urandom_range(0, 24)) - 16'd2;
		r.velocity  = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
		if ($urandom_range(0, 3) != 0)
			r.class_mask = 8'hff;
		return r;
	endfunction

	initial begin
		zone_req_t r;
		int        n;
		arst_n = 1'b0; start = 1'b0; cmd = CMD_CLEAR;
		pos_x = '0; pos_y = '0; prev_pos = '0; box_off_x = '0; box_off_y = '0;
		box_w = '0; box_h = '0; velocity = '0; class_mask = '0;
		zone_bounds = '0; zone_attr = '0;
		idle_pct = 0; req_count = 0;
		sb.reset_table();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: one zone of each type, a disabled one and a masked-out one
		r = noise_req(); r.cmd = CMD_CLEAR; send_request(r);
		for (int t = 0; t < 8; t++) begin
			r = zone_add();
			r.zone_bounds = {16'(t * 20 + 10), 16'(t * 20), 16'sd10, -16'sd10};
			r.zone_attr   = {1'b1, 3'(t), 8'h01, 16'(100 + t)};
			send_request(r);
		end
		r = zone_add(); r.zone_attr[27] = 1'b0; send_request(r);
		r = zone_add(); r.zone_attr[23:16] = 8'h00; send_request(r);
		for (int t = 0; t < 7; t++) begin
			r = query_req(CMD_EVENTS);
			r.pos_x = 16'sd0; r.pos_y = 16'(t * 20 + 5); r.class_mask = 8'h01;
			r.box_off_x = 16'd0; r.box_off_y = 16'd0; r.box_w = 16'd4; r.box_h = 16'd4;
			send_request(r);
		end
		r = query_req(CMD_POINT); r.pos_x = 16'd0; r.pos_y = 16'd5; r.class_mask = 8'h01;
		send_request(r);
		// fall toward the solid zone, then jump up toward its underside
		r = query_req(CMD_RES_Y); r.pos_x = 16'd0; r.pos_y = -16'sd2; r.prev_pos = -16'sd10;
		r.box_off_x = 16'd0; r.box_off_y = 16'd0; r.box_w = 16'd4; r.box_h = 16'd4;
		r.velocity = 16'sd3; r.class_mask = 8'h01; send_request(r);
		r.pos_y = 16'd8; r.prev_pos = 16'd12; r.velocity = -16'sd3; send_request(r);
		r = query_req(CMD_RES_X); r.pos_x = -16'sd12; r.prev_pos = -16'sd16; r.pos_y = 16'd2;
		r.box_off_x = 16'd0; r.box_off_y = 16'd0; r.box_w = 16'd4; r.box_h = 16'd4;
		r.velocity = 16'sd1; r.class_mask = 8'h01; send_request(r);
		r.pos_x = 16'd8; r.prev_pos = 16'd12; r.velocity = 16'h8000; send_request(r);
		r = noise_req(); r.cmd = CMD_UNUSED6; r.pos_x = 16'h7fff; send_request(r);
		r = noise_req(); r.cmd = CMD_UNUSED7; r.pos_x = 16'h8000; send_request(r);

		// random: clear, fill, query; some fills overflow the table
		n = 0;
		while (n < 1300) begin
			r = noise_req(); r.cmd = CMD_CLEAR; send_request(r); n++;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12)) begin
				send_request(zone_add()); n++;
			end
			repeat ($urandom_range(3, 15)) begin
				if ($urandom_range(0, 9) == 0)
					r = noise_req();
				else
					r = query_req(3'($urandom_range(CMD_POINT, CMD_EVENTS)));
				send_request(r); n++;
			end
		end
		@(negedge clk);
		start = 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
